FILE: src/bsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

  localparam int WIDTH_DEF = 8;

  // booth pair {q[0], q_1}
  localparam logic [1:0] BOOTH_SUB = 2'b10;
  localparam logic [1:0] BOOTH_ADD = 2'b01;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } bsm_state_t;

  typedef struct packed {
    logic load;      // take new operands
    logic step;      // run one booth round
    logic cap_round; // product register takes the result of this round
    logic cap_held;  // product register takes the held a:q value
  } bsm_cmd_t;

endpackage

`default_nettype wire

FILE: src/bsm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bsm_ctrl #(
  parameter int WIDTH = bsm_pkg::WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bsm_pkg::bsm_cmd_t     cmd
);
  import bsm_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  bsm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_round;
  logic             out_free;
  logic             capture;

  assign last_round = (cnt_r == CNT_W'(WIDTH - 1));
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (last_round) begin
          // result register free: capture the final round; still occupied: park the final value
          if (out_free) begin
            cmd.cap_round = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.cap_held = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign capture = cmd.cap_round || cmd.cap_held;

  always_comb begin
    if (capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/bsm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bsm_datapath #(
  parameter int WIDTH = bsm_pkg::WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic signed [WIDTH-1:0] in_multiplicand,
  input  wire logic signed [WIDTH-1:0] in_multiplier,
  input  wire bsm_pkg::bsm_cmd_t       cmd,
  output logic signed [2*WIDTH-1:0]    out_product
);
  import bsm_pkg::*;

  // accumulator carries one guard bit above the operand width
  logic [WIDTH:0]       m_r;
  logic [WIDTH:0]       a_r, a_nxt;
  logic [WIDTH-1:0]     q_r, q_nxt;
  logic                 q1_r, q1_nxt;
  logic [WIDTH:0]       a_sum;
  logic [2*WIDTH-1:0]   product_r;

  always_comb begin
    case ({q_r[0], q1_r})
      BOOTH_SUB: a_sum = a_r - m_r;
      BOOTH_ADD: a_sum = a_r + m_r;
      default:   a_sum = a_r;
    endcase
    // arithmetic shift right of a:q:q_1 as one register
    a_nxt  = {a_sum[WIDTH], a_sum[WIDTH:1]};
    q_nxt  = {a_sum[0], q_r[WIDTH-1:1]};
    q1_nxt = q_r[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r  <= {in_multiplicand[WIDTH-1], in_multiplicand};
      a_r  <= '0;
      q_r  <= in_multiplier;
      q1_r <= 1'b0;
    end else if (cmd.step) begin
      a_r  <= a_nxt;
      q_r  <= q_nxt;
      q1_r <= q1_nxt;
    end
    if (cmd.cap_round) begin
      product_r <= {a_nxt[WIDTH-1:0], q_nxt};
    end else if (cmd.cap_held) begin
      product_r <= {a_r[WIDTH-1:0], q_r};
    end
  end

  assign out_product = product_r;

endmodule

`default_nettype wire

FILE: src/booth_signed_multiplier_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Radix-2 Booth multiplier for two signed WIDTH-bit operands, giving the exact
// 2*WIDTH-bit signed product. The operands load on the transfer cycle, then one
// add/subtract-and-shift round per multiplier bit runs through the single shared
// (WIDTH+1)-bit adder. The product lands in an output register, so a new item can
// be taken while the last product waits; if that register is still occupied when
// the rounds finish, the engine holds until it frees and in_ready stays low
// meanwhile.
module booth_signed_multiplier_top #(
  parameter int WIDTH = bsm_pkg::WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [WIDTH-1:0] in_multiplicand,
  input  wire logic signed [WIDTH-1:0] in_multiplier,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [2*WIDTH-1:0]    out_product
);
  import bsm_pkg::*;

  bsm_cmd_t cmd;

  bsm_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  bsm_datapath #(
    .WIDTH(WIDTH)
  ) u_datapath (
    .clk            (clk),
    .in_multiplicand(in_multiplicand),
    .in_multiplier  (in_multiplier),
    .cmd            (cmd),
    .out_product    (out_product)
  );

  // the engine is busy right after taking an item
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("engine ready right after input transfer");

  // a new product only appears at the end of a computation
  a_product_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("product appeared without a computation");

  // no product can be produced in the cycle after a load
  a_no_early_product: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("product produced one cycle after load");

endmodule

`default_nettype wire
